### hdl/pna_pkg.sv
// ---------------------------------------------------------------------------
// pna_pkg: shared types and constants for the photometric normal/albedo block
// Field layouts of the input and result words, datapath widths and codes.
// ---------------------------------------------------------------------------
package pna_pkg;

	localparam int MAX_LIGHTS_DEF = 8;
	localparam int LANES          = 8;

	localparam int COEF_W  = 32;
	localparam int INT_W   = 8;
	localparam int PROD_W  = 40;             // coef * intensity, signed
	localparam int B_W     = 43;             // solved vector component, signed
	localparam int MAG_W   = 42;             // its magnitude
	localparam int HALF_W  = MAG_W / 2;
	localparam int SQP_W   = 2 * HALF_W;     // partial square
	localparam int SQ_W    = 2 * MAG_W;      // full square
	localparam int S_W     = 86;             // sum of three squares
	localparam int ROOT_W  = S_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int SQ_PER  = 2;              // root bits per stage
	localparam int SQ_ST   = (ROOT_W + SQ_PER - 1) / SQ_PER;
	localparam int ALB_W   = 32;
	localparam int NRM_W   = 16;
	localparam int NRM_SH  = 15;
	localparam int Q_W     = 16;
	localparam int DIV_W   = 59;
	localparam int DIV_PER = 2;              // quotient bits per stage
	localparam int DIV_ST  = Q_W / DIV_PER;
	localparam int ALB_SH  = 8;

	localparam logic [Q_W-1:0]   NRM_MAX = 16'd32767;
	localparam logic [1:0]       ROW_Z   = 2'd2;

	localparam logic             OP_LOAD  = 1'b0;
	localparam logic             OP_PIXEL = 1'b1;

	localparam int               CFG_IDX_W   = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHTS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALB_MIN = 1'b1;
	localparam int               CFG_W       = 32;
	localparam logic [3:0]       LIGHTS_RST  = 4'd8;

	typedef struct packed {
		logic              opcode;
		logic [1:0]        coef_row;
		logic [2:0]        coef_col;
		logic signed [31:0] coef_value;
		logic [7:0]        intensity_0;
		logic [7:0]        intensity_1;
		logic [7:0]        intensity_2;
		logic [7:0]        intensity_3;
		logic [7:0]        intensity_4;
		logic [7:0]        intensity_5;
		logic [7:0]        intensity_6;
		logic [7:0]        intensity_7;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [31:0]        albedo;
		logic               normal_valid;
	} out_word_t;

	typedef logic [2:0][B_W-1:0] bvec_t;

	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} vec_t;

	typedef struct packed {
		logic             hit;
		logic [ALB_W-1:0] alb;
		logic [2:0]       neg;
	} side_t;

endpackage

### hdl/pna_dot.sv
// ---------------------------------------------------------------------------
// pna_dot: coefficient table and b = P * I
// Four stages: intensity mask, lane products, pair sums, row sums.
// ---------------------------------------------------------------------------
module pna_dot #(
	parameter int MAX_LIGHTS = pna_pkg::MAX_LIGHTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  pna_pkg::in_word_t in_word,
	input  logic [3:0]        lights,
	output logic              b_valid,
	output pna_pkg::bvec_t    b
);
	import pna_pkg::*;

	localparam int TBL_N  = 3 * MAX_LIGHTS;
	localparam int TBL_AW = $clog2(TBL_N);

	logic signed [COEF_W-1:0] coef_q [TBL_N];
	logic                     acc;
	logic [3:0]               n_use;
	logic [LANES-1:0][INT_W-1:0] ivec;

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic [LANES-1:0][INT_W-1:0] int_s1;
	logic signed [PROD_W-1:0]    prod_s2 [3][LANES];
	logic signed [B_W-1:0]       part_s3 [3][4];
	bvec_t                       b_s4;

	assign acc   = in_valid && adv;
	assign ivec  = {in_word.intensity_7, in_word.intensity_6, in_word.intensity_5,
		in_word.intensity_4, in_word.intensity_3, in_word.intensity_2,
		in_word.intensity_1, in_word.intensity_0};
	assign n_use = (lights > 4'(MAX_LIGHTS)) ? 4'(MAX_LIGHTS) : lights;

	// loads outside the table are dropped
	always_ff @(posedge clk) begin
		if (acc && in_word.opcode == OP_LOAD && in_word.coef_row <= ROW_Z
			&& int'(in_word.coef_col) < MAX_LIGHTS) begin
			coef_q[TBL_AW'(int'(in_word.coef_row) * MAX_LIGHTS + int'(in_word.coef_col))]
				<= in_word.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_word.opcode == OP_PIXEL;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// unused lights contribute zero
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				int_s1[k] <= (4'(k) < n_use) ? ivec[k] : '0;
			end
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar k = 0; k < LANES; k++) begin : g_lane
			if (k < MAX_LIGHTS) begin : g_on
				always_ff @(posedge clk) begin
					if (adv) begin
						prod_s2[r][k] <= PROD_W'(coef_q[r * MAX_LIGHTS + k])
							* PROD_W'($signed({1'b0, int_s1[k]}));
					end
				end
			end else begin : g_off
				always_ff @(posedge clk) begin
					if (adv) begin
						prod_s2[r][k] <= '0;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int p = 0; p < 4; p++) begin
					part_s3[r][p] <= B_W'(prod_s2[r][2*p]) + B_W'(prod_s2[r][2*p+1]);
				end
				b_s4[r] <= part_s3[r][0] + part_s3[r][1] + part_s3[r][2] + part_s3[r][3];
			end
		end
	end

	assign b_valid = v_s4;
	assign b       = b_s4;

endmodule

### hdl/pna_sq.sv
// ---------------------------------------------------------------------------
// pna_sq: squared length of b
// Magnitudes, split partial squares, full squares, then their sum.
// ---------------------------------------------------------------------------
module pna_sq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    b_valid,
	input  pna_pkg::bvec_t          b,
	output logic                    s_valid,
	output logic [pna_pkg::S_W-1:0] s,
	output pna_pkg::vec_t           vec
);
	import pna_pkg::*;

	logic [2:0][B_W-1:0] ab;
	logic                v_s5, v_s6, v_s7, v_s8;
	vec_t                vec_s5, vec_s6, vec_s7, vec_s8;
	logic [2:0][SQP_W-1:0] hh_s6, hl_s6, ll_s6;
	logic [2:0][SQ_W-1:0]  sq_s7;
	logic [S_W-1:0]        s_s8;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			ab[r] = b[r][B_W-1] ? (~b[r] + 1'b1) : b[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s5 <= b_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				vec_s5.neg[r] <= b[r][B_W-1];
				vec_s5.mag[r] <= ab[r][MAG_W-1:0];
				hh_s6[r] <= SQP_W'(vec_s5.mag[r][MAG_W-1:HALF_W])
					* SQP_W'(vec_s5.mag[r][MAG_W-1:HALF_W]);
				hl_s6[r] <= SQP_W'(vec_s5.mag[r][MAG_W-1:HALF_W])
					* SQP_W'(vec_s5.mag[r][HALF_W-1:0]);
				ll_s6[r] <= SQP_W'(vec_s5.mag[r][HALF_W-1:0])
					* SQP_W'(vec_s5.mag[r][HALF_W-1:0]);
				// cross term appears twice
				sq_s7[r] <= (SQ_W'(hh_s6[r]) << (2 * HALF_W))
					+ (SQ_W'(hl_s6[r]) << (HALF_W + 1)) + SQ_W'(ll_s6[r]);
			end
			vec_s6 <= vec_s5;
			vec_s7 <= vec_s6;
			vec_s8 <= vec_s7;
			s_s8   <= S_W'(sq_s7[0]) + S_W'(sq_s7[1]) + S_W'(sq_s7[2]);
		end
	end

	assign s_valid = v_s8;
	assign s       = s_s8;
	assign vec     = vec_s8;

endmodule

### hdl/pna_sqrt.sv
// ---------------------------------------------------------------------------
// pna_sqrt: pipelined integer square root
// Restoring digit recurrence, a fixed number of root bits per stage.
// ---------------------------------------------------------------------------
module pna_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [pna_pkg::S_W-1:0]    rad,
	input  pna_pkg::vec_t              in_vec,
	output logic                       out_valid,
	output logic [pna_pkg::ROOT_W-1:0] root,
	output pna_pkg::vec_t              out_vec
);
	import pna_pkg::*;

	logic                v_s   [SQ_ST+1];
	logic [S_W-1:0]      rad_s [SQ_ST+1];
	logic [REM_W-1:0]    rem_s [SQ_ST+1];
	logic [ROOT_W-1:0]   root_s[SQ_ST+1];
	vec_t                vec_s [SQ_ST+1];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign vec_s[0]  = in_vec;

	for (genvar g = 0; g < SQ_ST; g++) begin : g_st
		logic [S_W-1:0]    rad_n;
		logic [REM_W-1:0]  rem_n;
		logic [ROOT_W-1:0] root_n;

		always_comb begin
			logic [REM_W+1:0] t;
			logic [REM_W+1:0] tr;
			rad_n  = rad_s[g];
			rem_n  = rem_s[g];
			root_n = root_s[g];
			for (int j = 0; j < SQ_PER; j++) begin
				if (g * SQ_PER + j < ROOT_W) begin
					t  = {rem_n, rad_n[S_W-1 -: 2]};
					tr = (REM_W+2)'({root_n, 2'b01});
					rad_n = rad_n << 2;
					if (t >= tr) begin
						rem_n  = REM_W'(t - tr);
						root_n = {root_n[ROOT_W-2:0], 1'b1};
					end else begin
						rem_n  = REM_W'(t);
						root_n = {root_n[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[g+1]  <= rad_n;
				rem_s[g+1]  <= rem_n;
				root_s[g+1] <= root_n;
				vec_s[g+1]  <= vec_s[g];
			end
		end
	end

	assign out_valid = v_s[SQ_ST];
	assign root      = root_s[SQ_ST];
	assign out_vec   = vec_s[SQ_ST];

endmodule

### hdl/pna_div.sv
// ---------------------------------------------------------------------------
// pna_div: pipelined unsigned divider for one normal component
// Restoring long division, a fixed number of quotient bits per stage.
// ---------------------------------------------------------------------------
module pna_div (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [pna_pkg::DIV_W-1:0]  dvd,
	input  logic [pna_pkg::ROOT_W-1:0] dvs,
	output logic [pna_pkg::Q_W-1:0]    quo
);
	import pna_pkg::*;

	logic [DIV_W-1:0]  rem_s [DIV_ST+1];
	logic [ROOT_W-1:0] dvs_s [DIV_ST+1];
	logic [Q_W-1:0]    quo_s [DIV_ST+1];

	assign rem_s[0] = dvd;
	assign dvs_s[0] = dvs;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < DIV_ST; g++) begin : g_st
		logic [DIV_W-1:0] rem_n;
		logic [Q_W-1:0]   quo_n;

		always_comb begin
			logic [DIV_W-1:0] t;
			rem_n = rem_s[g];
			quo_n = quo_s[g];
			for (int j = 0; j < DIV_PER; j++) begin
				t = DIV_W'(dvs_s[g]) << (Q_W - 1 - (g * DIV_PER + j));
				if (rem_n >= t) begin
					rem_n = rem_n - t;
					quo_n = {quo_n[Q_W-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1] <= rem_n;
				dvs_s[g+1] <= dvs_s[g];
				quo_s[g+1] <= quo_n;
			end
		end
	end

	assign quo = quo_s[DIV_ST];

endmodule

### hdl/photometric_normal_albedo_top.sv
// ---------------------------------------------------------------------------
// photometric_normal_albedo_top: Lambertian photometric stereo per pixel
// Solves b = P * I, albedo |b| and unit normal b/|b| in a 40-stage pipeline.
// ---------------------------------------------------------------------------
// in_word: load words write one Q8.24 coefficient of the light pseudo-inverse
// and give no result; pixel words give exactly one out_word each, in order.
// All coefficients in use must be loaded before pixels that read them.
// cfg port: cfg_we with cfg_index selects lights_in_use (0) or albedo_min (1);
// write only while no pixel is in flight.
// Throughput: one word per cycle while not stalled. Stages in order: dot product,
// squaring, square root, setup, division, output.
// The square root and the three dividers set the depth; each stage resolves
// two bits.
// Stall: the whole pipeline holds when out_valid is high and out_stall is
// asserted, so in_stall follows out_stall in that case; nothing is dropped.
// Reset: pipeline emptied, lights_in_use = 8, albedo_min = 0; the coefficient
// table is not cleared.
// ---------------------------------------------------------------------------
module photometric_normal_albedo_top #(
	parameter int MAX_LIGHTS = pna_pkg::MAX_LIGHTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pna_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pna_pkg::out_word_t            out_word,
	input  logic                          cfg_we,
	input  logic [pna_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pna_pkg::CFG_W-1:0]     cfg_data
);
	import pna_pkg::*;

	logic             adv;
	logic [3:0]       lights_q;
	logic [ALB_W-1:0] albedo_min_q;

	logic             b_valid;
	bvec_t            b;
	logic             s_valid;
	logic [S_W-1:0]   s;
	vec_t             s_vec;
	logic             r_valid;
	logic [ROOT_W-1:0] root;
	vec_t             r_vec;

	logic [ROOT_W-ALB_SH-1:0] alb_wide;
	logic [ALB_W-1:0]         alb_sat;

	logic [2:0][DIV_W-1:0] dvd_s1;
	logic [ROOT_W-1:0]     dvs_s1;
	logic                  vld_s  [DIV_ST+1];
	side_t                 side_s [DIV_ST+1];
	logic [2:0][Q_W-1:0]   quo;
	logic [2:0][NRM_W-1:0] nrm;

	out_word_t out_word_q;
	logic      out_valid_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lights_q     <= LIGHTS_RST;
			albedo_min_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIGHTS:  lights_q     <= cfg_data[3:0];
				CFG_ALB_MIN: albedo_min_q <= cfg_data[ALB_W-1:0];
				default: ;
			endcase
		end
	end

	pna_dot #(.MAX_LIGHTS(MAX_LIGHTS)) u_dot (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(in_valid),
		.in_word (in_word),
		.lights  (lights_q),
		.b_valid (b_valid),
		.b       (b)
	);

	pna_sq u_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.b_valid(b_valid),
		.b      (b),
		.s_valid(s_valid),
		.s      (s),
		.vec    (s_vec)
	);

	pna_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_valid),
		.rad      (s),
		.in_vec   (s_vec),
		.out_valid(r_valid),
		.root     (root),
		.out_vec  (r_vec)
	);

	// albedo saturates to 32 bits
	assign alb_wide = root[ROOT_W-1:ALB_SH];
	assign alb_sat  = (|alb_wide[ROOT_W-ALB_SH-1:ALB_W]) ? '1 : alb_wide[ALB_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_ST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= r_valid;
			for (int i = 1; i <= DIV_ST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// rounding: add half the divisor before dividing
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				dvd_s1[c] <= (DIV_W'(r_vec.mag[c]) << NRM_SH) + DIV_W'(root >> 1);
			end
			dvs_s1         <= root;
			side_s[0].hit  <= alb_sat > albedo_min_q;
			side_s[0].alb  <= alb_sat;
			side_s[0].neg  <= r_vec.neg;
			for (int i = 1; i <= DIV_ST; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		pna_div u_div (
			.clk(clk),
			.adv(adv),
			.dvd(dvd_s1[c]),
			.dvs(dvs_s1),
			.quo(quo[c])
		);
	end

	always_comb begin
		logic [Q_W-1:0] qs;
		for (int c = 0; c < 3; c++) begin
			qs = (quo[c] > NRM_MAX) ? NRM_MAX : quo[c];
			nrm[c] = side_s[DIV_ST].neg[c] ? NRM_W'(~qs + 1'b1) : NRM_W'(qs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[DIV_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s[DIV_ST].hit) begin
				out_word_q.normal_x     <= nrm[0];
				out_word_q.normal_y     <= nrm[1];
				out_word_q.normal_z     <= nrm[2];
				out_word_q.albedo       <= side_s[DIV_ST].alb;
				out_word_q.normal_valid <= 1'b1;
			end else begin
				out_word_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// at or below threshold every field is zero
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.normal_valid |->
			out_word.normal_x == 16'sd0 && out_word.normal_y == 16'sd0
			&& out_word.normal_z == 16'sd0 && out_word.albedo == 32'd0)
		else $error("invalid result carries nonzero fields");

	// saturation keeps normals inside -32767..32767
	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.normal_valid |->
			out_word.normal_x != 16'sh8000 && out_word.normal_y != 16'sh8000
			&& out_word.normal_z != 16'sh8000)
		else $error("normal component out of range");

	// a valid normal needs a nonzero albedo
	a_albedo_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.normal_valid |-> out_word.albedo != 32'd0)
		else $error("valid normal with zero albedo");

endmodule
